[hdl/sfb_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the seam feather blend core.
// Used by the divider stage, the top level and the port checker; depends on nothing.
package sfb_pkg;

	localparam int MAX_OVERLAP = 4096;

	localparam int CH_W  = 8;
	localparam int NCH   = 3;
	localparam int CFG_W = 13;
	localparam int OFS_W = 12;

	localparam int WID_W = $clog2(MAX_OVERLAP + 1);
	localparam int EXT_W = (CFG_W > OFS_W) ? ((CFG_W > WID_W) ? CFG_W : WID_W)
	                                       : ((OFS_W > WID_W) ? OFS_W : WID_W);
	localparam int DIV_W = WID_W + CH_W;

	localparam int BITS_PER_STAGE = 2;
	localparam int DIV_STAGES     = CH_W / BITS_PER_STAGE;

	localparam int PIX_W       = NCH * CH_W;
	localparam int IN_BITS     = 2 * PIX_W + OFS_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((PIX_W + 7) / 8) * 8;

	typedef logic [NCH-1:0][CH_W-1:0] pix_t;

	typedef struct packed {
		logic [NCH-1:0][DIV_W-1:0] rem;
		pix_t                      quo;
		logic [DIV_W-1:0]          dvs;
	} div_t;

endpackage

[hdl/sfb_div_stage.sv]
`timescale 1ns / 1ps
// One pipeline stage of the restoring divider: two quotient bits per channel.
// Depends on sfb_pkg for the widths and the stage payload type.
module sfb_div_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  sfb_pkg::div_t in_data,
	output logic         out_valid,
	output sfb_pkg::div_t out_data
);
	import sfb_pkg::*;

	div_t nxt;

	always_comb begin
		nxt = in_data;
		for (int c = 0; c < NCH; c++) begin
			for (int s = 0; s < BITS_PER_STAGE; s++) begin
				if (nxt.rem[c] >= (in_data.dvs >> s)) begin
					nxt.rem[c] = nxt.rem[c] - (in_data.dvs >> s);
					nxt.quo[c] = {nxt.quo[c][CH_W-2:0], 1'b1};
				end else begin
					nxt.quo[c] = {nxt.quo[c][CH_W-2:0], 1'b0};
				end
			end
		end
		nxt.dvs = in_data.dvs >> BITS_PER_STAGE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

[hdl/seam_feather_blend_core.sv]
`timescale 1ns / 1ps
// Pipeline: seven register stages, from the input register through the divider stages.
// Throughput: one transaction per cycle; the whole pipeline holds while the output is stalled.
// The rate is set by the pipelined restoring divider, two quotient bits per stage.
// Reset clears the valid bits and sets the overlap width to one; payload is not reset.
// Depends on sfb_pkg and sfb_div_stage.
module seam_feather_blend_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfb_pkg::CFG_W-1:0]       cfg_data,     // overlap_width
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// first_red, first_green, first_blue, second_red, second_green, second_blue,
	// overlap_offset, zero fill
	input  logic [sfb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [sfb_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // out_red, out_green, out_blue
);
	import sfb_pkg::*;

	logic [WID_W-1:0] width_q;
	logic [EXT_W-1:0] cfg_ext;
	logic [EXT_W-1:0] cfg_eff;
	logic             advance;

	pix_t             in_first;
	pix_t             in_second;
	logic [EXT_W-1:0] in_ofs_ext;
	logic [WID_W-1:0] in_k;

	logic             valid_s1;
	pix_t             a_s1;
	pix_t             b_s1;
	logic [WID_W-1:0] k_s1;
	logic [WID_W-1:0] wk_s1;

	logic                      valid_s2;
	logic [NCH-1:0][DIV_W-1:0] pa_s2;
	logic [NCH-1:0][DIV_W-1:0] pb_s2;

	logic stg_valid [DIV_STAGES+1];
	div_t stg_data  [DIV_STAGES+1];

	assign cfg_ready = 1'b1;
	assign cfg_ext   = EXT_W'(cfg_data);

	always_comb begin
		if (cfg_ext == '0) begin
			cfg_eff = EXT_W'(1);
		end else if (cfg_ext > EXT_W'(MAX_OVERLAP)) begin
			cfg_eff = EXT_W'(MAX_OVERLAP);
		end else begin
			cfg_eff = cfg_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WID_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			width_q <= WID_W'(cfg_eff);
		end
	end

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = advance;

	assign in_first   = s_axis_tdata[PIX_W-1:0];
	assign in_second  = s_axis_tdata[2*PIX_W-1:PIX_W];
	assign in_ofs_ext = EXT_W'(s_axis_tdata[2*PIX_W +: OFS_W]);

	// A black second pixel forces the offset to zero, which returns the first pixel exactly.
	always_comb begin
		if (in_second == '0) begin
			in_k = '0;
		end else if (in_ofs_ext > EXT_W'(width_q)) begin
			in_k = width_q;
		end else begin
			in_k = WID_W'(in_ofs_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			stg_valid[0] <= 1'b0;
		end else if (advance) begin
			valid_s1    <= s_axis_tvalid;
			valid_s2    <= valid_s1;
			stg_valid[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1  <= in_first;
			b_s1  <= in_second;
			k_s1  <= in_k;
			wk_s1 <= width_q - in_k;
			for (int c = 0; c < NCH; c++) begin
				pa_s2[c]            <= DIV_W'(a_s1[c]) * DIV_W'(wk_s1);
				pb_s2[c]            <= DIV_W'(b_s1[c]) * DIV_W'(k_s1);
				stg_data[0].rem[c]  <= DIV_W'(pa_s2[c] + pb_s2[c]);
			end
			stg_data[0].quo <= '0;
			stg_data[0].dvs <= DIV_W'(width_q) << (CH_W - 1);
		end
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		sfb_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.in_valid  (stg_valid[g]),
			.in_data   (stg_data[g]),
			.out_valid (stg_valid[g+1]),
			.out_data  (stg_data[g+1])
		);
	end

	assign m_axis_tvalid = stg_valid[DIV_STAGES];
	assign m_axis_tdata  = OUT_TDATA_W'(stg_data[DIV_STAGES].quo);

endmodule

[hdl/sfb_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the seam feather blend core, attached by the bind below.
// Depends on sfb_pkg and on the ports of seam_feather_blend_core.
module sfb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [sfb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [sfb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import sfb_pkg::*;

	logic in_acc;
	logic keeps_first;

	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign keeps_first = (s_axis_tdata[2*PIX_W-1:PIX_W] == '0)
	                  || (s_axis_tdata[2*PIX_W +: OFS_W] == '0);

	// The input side is held exactly when a result waits at the output.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow the output stall");

	// A black second pixel or a zero offset returns the first pixel unchanged.
	a_first_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && keeps_first) ##1 s_axis_tready ##1 s_axis_tready ##1 s_axis_tready
		##1 s_axis_tready ##1 s_axis_tready ##1 s_axis_tready
		|=> m_axis_tvalid && (m_axis_tdata[PIX_W-1:0] == $past(s_axis_tdata[PIX_W-1:0], 7)))
		else $error("first pixel did not pass through unchanged");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction withdrawn while stalled");

	a_out_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

endmodule

bind seam_feather_blend_core sfb_checker u_sfb_checker (.*);

[tb/seam_feather_blend_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for seam_feather_blend_core: directed and random pixel blends
// over many overlap widths, with bursty input and a stalling output. Depends on sfb_pkg.
module seam_feather_blend_core_tb;
	import sfb_pkg::*;

	typedef struct packed {
		logic [OFS_W-1:0] offset;
		pix_t             second;
		pix_t             first;
	} blend_item_t;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data      = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int unsigned width_shadow = 1;
	pix_t        blended_queue[$];
	int unsigned mismatch_count = 0;
	bit          bursty = 1'b0;
	int          burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int unsigned cycle_count = 0;
	string       chan_name[NCH] = '{"red", "green", "blue"};
	pix_t        got_pix;
	pix_t        want_pix;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	seam_feather_blend_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	function automatic pix_t blend_pixel(blend_item_t px, int unsigned reg_width);
		int unsigned w;
		int unsigned k;
		int unsigned num;
		pix_t        res;
		w = reg_width;
		if (w == 0) begin
			w = 1;
		end
		if (w > MAX_OVERLAP) begin
			w = MAX_OVERLAP;
		end
		k = px.offset;
		if (k > w) begin
			k = w;
		end
		if (px.second == '0) begin
			return px.first;
		end
		for (int c = 0; c < NCH; c++) begin
			num = px.first[c] * (w - k) + px.second[c] * k;
			res[c] = CH_W'(num / w);
		end
		return res;
	endfunction

	function automatic blend_item_t make_item(pix_t first, pix_t second, int unsigned offset);
		blend_item_t px;
		px.first = first;
		px.second = second;
		px.offset = OFS_W'(offset);
		return px;
	endfunction

	function automatic logic [CH_W-1:0] rand_channel();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return CH_W'($urandom);
			end
		endcase
	endfunction

	function automatic blend_item_t rand_item(int unsigned reg_width);
		blend_item_t px;
		int unsigned w;
		int unsigned sel;
		w = (reg_width == 0) ? 1 : ((reg_width > MAX_OVERLAP) ? MAX_OVERLAP : reg_width);
		for (int c = 0; c < NCH; c++) begin
			px.first[c] = rand_channel();
			px.second[c] = rand_channel();
		end
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			px.second = '0;
		end else if (sel == 1) begin
			px.second = '0;
			px.second[$urandom_range(0, NCH - 1)] = CH_W'($urandom_range(1, 255));
		end
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			px.offset = OFS_W'($urandom_range(0, (w + 2 > 4095) ? 4095 : w + 2));
		end else if (sel == 5) begin
			px.offset = OFS_W'($urandom_range((w > 1) ? w - 1 : 0, (w + 1 > 4095) ? 4095 : w + 1));
		end else begin
			px.offset = OFS_W'($urandom_range(0, 4095));
		end
		return px;
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("t=%0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		case (stall_mode)
			STALL_NONE: begin
				m_axis_tready <= 1'b1;
			end
			STALL_RANDOM: begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
			STALL_PERIODIC: begin
				m_axis_tready <= ((cycle_count % 7) >= 3);
			end
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_left = $urandom_range(5, 30);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_pix = m_axis_tdata[PIX_W-1:0];
			if (blended_queue.size() == 0) begin
				report_mismatch($sformatf("result %h arrived with none expected", got_pix));
			end else begin
				want_pix = blended_queue.pop_front();
				for (int c = 0; c < NCH; c++) begin
					if (got_pix[c] !== want_pix[c]) begin
						report_mismatch($sformatf("out_%s: got %h, expected %h",
							chan_name[c], got_pix[c], want_pix[c]));
					end
				end
			end
		end
	end

	task automatic send_pixel(blend_item_t px);
		s_axis_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, px};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		blended_queue.push_back(blend_pixel(px, width_shadow));
		if (bursty) begin
			if (burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		s_axis_tvalid <= 1'b0;
		while (blended_queue.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic write_width(int unsigned value);
		drain_results();
		cfg_data <= CFG_W'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		width_shadow = value & 13'h1FFF;
	endtask

	task automatic test_reset_width();
		send_pixel(make_item({8'hFF, 8'h80, 8'h00}, {8'h00, 8'h7F, 8'hFF}, 0));
		send_pixel(make_item({8'hFF, 8'h80, 8'h00}, {8'h00, 8'h7F, 8'hFF}, 1));
		send_pixel(make_item({8'h12, 8'h34, 8'h56}, {8'hFF, 8'hFF, 8'hFF}, 4095));
		send_pixel(make_item({8'hFF, 8'hFF, 8'hFF}, '0, 1));
	endtask

	task automatic test_zero_width();
		write_width(0);
		send_pixel(make_item({8'h00, 8'hFF, 8'h55}, {8'hFF, 8'h00, 8'hAA}, 0));
		send_pixel(make_item({8'h00, 8'hFF, 8'h55}, {8'hFF, 8'h00, 8'hAA}, 1));
		send_pixel(make_item({8'h00, 8'hFF, 8'h55}, {8'hFF, 8'h00, 8'hAA}, 2));
	endtask

	task automatic test_width_saturation();
		write_width(8191);
		send_pixel(make_item({8'hFF, 8'hFF, 8'hFF}, {8'h01, 8'h01, 8'h01}, 4095));
		send_pixel(make_item({8'hFF, 8'h00, 8'h80}, {8'h00, 8'hFF, 8'h81}, 2048));
		send_pixel(make_item({8'hFF, 8'hFF, 8'hFF}, {8'hFF, 8'hFF, 8'hFF}, 0));
		write_width(4097);
		send_pixel(make_item({8'h00, 8'h00, 8'h00}, {8'hFF, 8'hFF, 8'hFF}, 4095));
	endtask

	task automatic test_offset_clamp();
		write_width(100);
		send_pixel(make_item({8'h10, 8'h20, 8'h30}, {8'hF0, 8'hE0, 8'hD0}, 101));
		send_pixel(make_item({8'h10, 8'h20, 8'h30}, {8'hF0, 8'hE0, 8'hD0}, 4095));
		send_pixel(make_item({8'h10, 8'h20, 8'h30}, {8'hF0, 8'hE0, 8'hD0}, 100));
		send_pixel(make_item({8'hFF, 8'hFF, 8'hFF}, {8'h00, 8'h00, 8'h01}, 99));
		send_pixel(make_item({8'hC8, 8'h64, 8'h01}, {8'h01, 8'hC8, 8'hFE}, 50));
	endtask

	task automatic test_black_second();
		write_width(16);
		send_pixel(make_item({8'hAB, 8'hCD, 8'hEF}, '0, 0));
		send_pixel(make_item({8'hAB, 8'hCD, 8'hEF}, '0, 8));
		send_pixel(make_item({8'hAB, 8'hCD, 8'hEF}, '0, 16));
		send_pixel(make_item({8'hFF, 8'hFF, 8'hFF}, '0, 4095));
		send_pixel(make_item({8'hAB, 8'hCD, 8'hEF}, {8'h00, 8'h01, 8'h00}, 8));
	endtask

	task automatic test_random_blend();
		int unsigned widths[14];
		widths = '{2, 3, 7, 13, 64, 255, 256, 1000, 4095, 4096, 8191, 0, 1, 1};
		widths[12] = $urandom_range(1, 4096);
		widths[13] = $urandom_range(4097, 8191);
		for (int p = 0; p < 14; p++) begin
			write_width(widths[p]);
			stall_mode = stall_mode_t'(p % 4);
			bursty = (p % 3 != 0);
			burst_left = $urandom_range(1, 24);
			repeat (82) send_pixel(rand_item(width_shadow));
		end
		bursty = 1'b0;
		stall_mode = STALL_NONE;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_width();
		test_zero_width();
		test_width_saturation();
		test_offset_clamp();
		test_black_second();
		test_random_blend();
		drain_results();
		if (blended_queue.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", blended_queue.size()));
		end
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
